FILE: rtl/core/cel_pkg.sv
// shared types and constants for the coalescing event log
// no dependencies
`default_nettype none
package cel_pkg;
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [63:0] sequence_no;
    logic [63:0] first_frame;
    logic [63:0] last_frame;
    logic [31:0] count;
    logic [31:0] code;
  } rec_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] frame_no;
    logic [31:0] event_code;
    logic [3:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        merged;
    logic        evicted;
    logic        record_valid;
    logic [63:0] sequence_res;
    logic [63:0] first_frame;
    logic [63:0] last_frame;
    logic [31:0] hit_count;
    logic [31:0] code_out;
    logic [63:0] dropped_total;
    logic [4:0]  entries_held;
  } rsp_t;

  // control given to each cell for one step
  typedef struct packed {
    logic shift;   // cell takes its upper neighbour's record
    logic load;    // cell takes the inject record
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/core/cel_if.sv
// valid/ready channel interfaces for the coalescing event log
// depends on cel_pkg
`default_nettype none
interface cel_req_if;
  logic          valid;
  logic          ready;
  cel_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cel_rsp_if;
  logic          valid;
  logic          ready;
  cel_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cel_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cel_cell.sv
// one slot of the log: holds a record, takes its neighbour's or the inject
// depends on cel_pkg
`default_nettype none
module cel_cell (
  input  wire             clk,
  input  cel_pkg::cell_ctl_t ctl,
  input  cel_pkg::rec_t   upper,
  input  cel_pkg::rec_t   inject,
  output cel_pkg::rec_t   rec
);
  import cel_pkg::*;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rec <= inject;
    end else if (ctl.shift) begin
      rec <= upper;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/coalescing_event_log_top.sv
// top level of the coalescing event log: controller and chain of cells
// depends on cel_pkg, cel_if and cel_cell
`default_nettype none
// Coalescing event log. Records sit in a chain of LOG_DEPTH cells, oldest
// at cell 0. During a scan the ring rotates one place per cycle (cell i
// takes cell i+1, the top cell takes cell 0), so every record passes cell 0,
// where the single comparator looks at it; when the scan ends the ring is
// back in order. An append then has a build state: when a record is
// dropped (the hit record, or the oldest when the log is full) every cell
// from the dropped slot upwards takes its upper neighbour, and the cell just
// past the kept records loads the new or merged record. A read picks its
// record as it passes cell 0. One item is in work at a time; the result
// sits in an output register, so the input is free again while that result
// waits, and a following result is held back only while the register still
// holds an untaken one.
module coalescing_event_log_top #(
  parameter int LOG_DEPTH = 16
) (
  input  wire       clk,
  input  wire       rst,
  cel_req_if.sink   req,
  cel_rsp_if.source rsp,
  cel_cfg_if.sink   cfg
);
  import cel_pkg::*;

  localparam int CW = $clog2(LOG_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_BUILD  = 5'b00100,
    S_FINISH = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t        state;
  req_t          cur;
  logic [31:0]   window;
  logic [CW-1:0] fill, cnt, hit_pos;
  logic [63:0]   next_seq, drops;
  logic          hit, evict;
  rec_t          found;
  rsp_t          out;
  logic          out_valid;

  rec_t          recs [LOG_DEPTH];
  rec_t          new_rec;

  logic          match, full, do_drop, out_free, rep_valid;
  logic [64:0]   delta;
  logic [CW-1:0] drop_pos, load_pos;

  // the dropped slot and the slot that takes the new record in the build cycle
  assign full     = (fill == CW'(LOG_DEPTH));
  assign do_drop  = hit || full;
  assign drop_pos = hit ? hit_pos : '0;
  assign load_pos = do_drop ? fill - CW'(1) : fill;

  // chain of cells: rotate during the scan, compact and load during the build
  for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift = (state == S_SCAN) ||
                       ((state == S_BUILD) && do_drop && (CW'(g) >= drop_pos));
    assign ctl.load  = (state == S_BUILD) && (CW'(g) == load_pos);
    cel_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .upper (recs[(g + 1) % LOG_DEPTH]),
      .inject(new_rec),
      .rec   (recs[g])
    );
  end

  // compare at cell 0; the borrow of the subtraction says the frame is earlier
  always_comb begin
    delta = {1'b0, cur.frame_no} - {1'b0, recs[0].last_frame};
    match = !delta[64] && (delta[63:32] == 32'd0) && (delta[31:0] <= window) &&
            (recs[0].code == cur.event_code) && (cnt < fill);
  end

  // merged record on a hit, fresh record otherwise
  always_comb begin
    new_rec = found;
    if (hit) begin
      new_rec.last_frame = cur.frame_no;
      new_rec.count      = (found.count == '1) ? found.count : found.count + 32'd1;
    end else begin
      new_rec.sequence_no = next_seq;
      new_rec.first_frame = cur.frame_no;
      new_rec.last_frame  = cur.frame_no;
      new_rec.count       = 32'd1;
      new_rec.code        = cur.event_code;
    end
  end

  always_comb begin
    rep_valid = (cur.opcode == OP_APPEND) ||
                ((cur.opcode == OP_READ) && (32'(cur.entry_index) < 32'(fill)));
  end

  // the output register may take a result when empty or being drained
  assign out_free  = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      next_seq  <= 64'd1;
      drops     <= '0;
      out_valid <= 1'b0;
      window    <= '0;
      cnt       <= '0;
      hit       <= 1'b0;
      evict     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) window <= cfg.data;
      if ((state == S_OUT) && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur   <= req.data;
            cnt   <= '0;
            hit   <= 1'b0;
            evict <= 1'b0;
            unique case (req.data.opcode) inside
              OP_APPEND, OP_READ: state <= S_SCAN;
              OP_CLEAR: begin
                fill     <= '0;
                next_seq <= 64'd1;
                drops    <= '0;
                state    <= S_OUT;
              end
              default:  state <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          // later positions are newer, so the last match wins
          if ((cur.opcode == OP_APPEND) && match) begin
            hit     <= 1'b1;
            hit_pos <= cnt;
            found   <= recs[0];
          end
          if ((cur.opcode == OP_READ) && (32'(cnt) == 32'(cur.entry_index))) begin
            found <= recs[0];
          end
          if (cnt == CW'(LOG_DEPTH - 1)) begin
            cnt   <= '0;
            state <= (cur.opcode == OP_APPEND) ? S_BUILD : S_OUT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_BUILD: begin
          found <= new_rec;
          if (!hit) begin
            evict <= full;
            if (full) begin
              if (drops != '1) drops <= drops + 64'd1;
            end else begin
              fill <= fill + CW'(1);
            end
            if (next_seq != '1) next_seq <= next_seq + 64'd1;
          end
          state <= S_OUT;
        end
        S_FINISH: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      out.merged        <= (cur.opcode == OP_APPEND) && hit;
      out.evicted       <= (cur.opcode == OP_APPEND) && evict;
      out.record_valid  <= rep_valid;
      out.sequence_res  <= rep_valid ? found.sequence_no : '0;
      out.first_frame   <= rep_valid ? found.first_frame : '0;
      out.last_frame    <= rep_valid ? found.last_frame : '0;
      out.hit_count     <= rep_valid ? found.count : '0;
      out.code_out      <= rep_valid ? found.code : '0;
      out.dropped_total <= drops;
      out.entries_held  <= 5'(fill);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(LOG_DEPTH)) else $error("fill above depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_seq_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_seq != '0) else $error("sequence wrapped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire
